/* rtl/cst_pkg.sv */
package cst_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERASED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic                load;
        logic                idx_clr;
        logic                idx_inc;
        logic                rd_en;
        logic                rd_next;
        logic                wr_en;
        logic                wr_key;
        logic                cnt_clr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } cst_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic at_end;
        logic last_shift;
        logic full;
        logic out_free;
    } cst_stat_t;

endpackage

/* rtl/cst_req_if.sv */
interface cst_req_if
    import cst_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [KEY_IN_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

/* rtl/cst_rsp_if.sv */
interface cst_rsp_if
    import cst_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    modport source (output valid, output status, output count, output is_empty, input ready);
    modport sink   (input valid, input status, input count, input is_empty, output ready);
endinterface

/* rtl/cst_ram.sv */
module cst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/cst_ctrl.sv */
module cst_ctrl
    import cst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    input  cst_stat_t         stat,
    output cst_cmd_t          cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_SHRD = 6'b001000,
        S_SHWR = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                erase_reg, erase_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            erase_reg  <= 1'b0;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            erase_reg  <= erase_next;
            status_reg <= status_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        erase_next     = erase_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.out_status = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_mode == MODE_INSERT || in_mode == MODE_ERASE)
                    begin
                        erase_next  = (in_mode == MODE_ERASE);
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RD;
                    end
                    else
                    begin
                        cmd.cnt_clr = 1'b1;
                        status_next = ST_CLEARED;
                        state_next  = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                if (stat.at_end)
                begin
                    // scan ran past the last stored key without a match
                    if (erase_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (stat.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_key  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        status_next = ST_INSERTED;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.hit)
                begin
                    if (erase_reg)
                    begin
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_SHRD:
            begin
                if (stat.last_shift)
                begin
                    cmd.cnt_dec = 1'b1;
                    status_next = ST_ERASED;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_SHRD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/cst_dp.sv */
module cst_dp
    import cst_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_IN_W-1:0] in_key,
    input  cst_cmd_t            cmd,
    output cst_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count,
    output logic                out_is_empty
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_empty_reg;

    logic [CNT_W-1:0]     idx_plus;
    logic [CNT_W:0]       idx_plus_wide;
    logic [ADDR_W-1:0]    rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic [KEY_WIDTH-1:0] wr_data;

    assign idx_plus      = idx_reg + CNT_W'(1);
    assign idx_plus_wide = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign rd_addr       = cmd.rd_next ? idx_plus[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data       = cmd.wr_key ? key_reg : rd_data;

    cst_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (idx_reg[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus;
        end

        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= KEY_WIDTH'(in_key);
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_count_reg  <= COUNT_W'(cnt_reg);
            out_empty_reg  <= (cnt_reg == '0);
        end
    end

    assign stat.hit        = (rd_data == key_reg);
    assign stat.at_end     = (idx_reg == cnt_reg);
    assign stat.last_shift = (idx_plus_wide >= {1'b0, cnt_reg});
    assign stat.full       = (cnt_reg == CNT_W'(CAPACITY));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_count    = out_count_reg;
    assign out_is_empty = out_empty_reg;

endmodule

/* rtl/compacting_set_table.sv */
// Set of up to CAPACITY unique keys, kept packed in insertion order in an
// entry RAM with one read port and one write port. One transaction at a time:
// insert (rejects a duplicate, or a new key when full), erase (removes the
// key and closes the gap) or clear, each answered by one response
// transaction carrying status, count and an empty flag. The RAM gives one
// read per compare or per shift step: insert and erase scan the stored keys
// one read and compare at a time, then erase moves each later key down by a
// read and a write. A new request is taken while the previous response
// still waits to be taken.
module compacting_set_table
    import cst_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_req_if.sink   req,
    cst_rsp_if.source rsp
);

    cst_cmd_t  cmd;
    cst_stat_t stat;

    cst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cst_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_key       (req.key),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_count    (rsp.count),
        .out_is_empty (rsp.is_empty)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import cst_pkg::*;
;

    // both clear codes: the block decodes clear from the high bit alone
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALT = 2'd3;

    localparam logic [KEY_IN_W-1:0] KEY_MASK =
        (KEY_WIDTH_DEF >= KEY_IN_W) ? '1 : KEY_IN_W'((64'd1 << KEY_WIDTH_DEF) - 64'd1);

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY_DEF + 8;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int PHASE_ITEMS   = 125;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } set_result_t;

    logic clk = 1'b0;
    logic rst_n;

    cst_req_if req_ch ();
    cst_rsp_if rsp_ch ();

    compacting_set_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // shadow copy of the set
    logic [KEY_IN_W-1:0] shadow_keys [CAPACITY_DEF];
    int                  shadow_fill = 0;
    set_result_t         pending_results [$];
    set_result_t         oldest_result;

    int error_count = 0;
    int sent_count  = 0;
    int peak_fill   = 0;
    int status_seen [6];
    int idle_cycles = 0;
    int stall_left  = 0;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // applies one operation to the shadow set and returns the response it should give
    function automatic set_result_t apply_set_op(input logic [MODE_W-1:0] mode,
                                                 input logic [KEY_IN_W-1:0] key_in);
        logic [KEY_IN_W-1:0] k;
        int                  pos;
        set_result_t         r;
        k   = key_in & KEY_MASK;
        pos = -1;
        if (mode[1])
        begin
            shadow_fill = 0;
            r.status = ST_CLEARED;
        end
        else
        begin
            for (int i = 0; i < shadow_fill; i++)
                if (pos < 0 && shadow_keys[i] == k)
                    pos = i;
            if (mode == MODE_INSERT)
            begin
                // duplicate check wins over the full check
                if (pos >= 0)
                    r.status = ST_DUPLICATE;
                else if (shadow_fill >= CAPACITY_DEF)
                    r.status = ST_FULL;
                else
                begin
                    shadow_keys[shadow_fill] = k;
                    shadow_fill++;
                    r.status = ST_INSERTED;
                end
            end
            else if (pos < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                shadow_fill--;
                for (int i = pos; i < shadow_fill; i++)
                    shadow_keys[i] = shadow_keys[i + 1];
                r.status = ST_ERASED;
            end
        end
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        r.count    = shadow_fill[COUNT_W-1:0];
        r.is_empty = (shadow_fill == 0);
        return r;
    endfunction

    function automatic logic [KEY_IN_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && shadow_fill > 0)
            return shadow_keys[$urandom_range(0, shadow_fill - 1)];
        if (r < 7)
            return $urandom_range(0, 23);
        return $urandom;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_IN_W-1:0] key);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.mode  = mode;
        req_ch.key   = key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(apply_set_op(mode, key));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_insert_erase_basics();
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF);
        send_request(MODE_INSERT, 32'h0000_0000);
        send_request(MODE_ERASE,  32'h0000_0000);
        send_request(MODE_ERASE,  32'h5A5A_A5A5);
        send_request(MODE_CLEAR,  32'h0000_0000);
        // clear on an empty set, through the alternate code
        send_request(MODE_CLEAR_ALT, 32'hFFFF_FFFF);
        wait_for_drain();
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < CAPACITY_DEF; i++)
            send_request(MODE_INSERT, (32'h1 << i) | (32'hA000_0000 >> i));
        send_request(MODE_INSERT, 32'h8000_0000);
        send_request(MODE_INSERT, (32'h1 << 3) | (32'hA000_0000 >> 3));
        send_request(MODE_ERASE,  (32'h1 << 7) | (32'hA000_0000 >> 7));
        send_request(MODE_ERASE,  (32'h1 << 15) | (32'hA000_0000 >> 15));
        send_request(MODE_INSERT, 32'h8000_0000);
        send_request(MODE_CLEAR_ALT, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        int                  r;
        int                  insert_weight;
        logic [MODE_W-1:0]   mode;
        for (int p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++)
        begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            insert_weight   = $urandom_range(35, 85);
            repeat (PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    mode = $urandom_range(0, 1) ? MODE_CLEAR : MODE_CLEAR_ALT;
                else if (r < 2 + insert_weight * 98 / 100)
                    mode = MODE_INSERT;
                else
                    mode = MODE_ERASE;
                send_request(mode, pick_key());
            end
            wait_for_drain();
        end
    endtask

    always @(negedge clk)
    begin
        if (receiver_steady)
            rsp_ch.ready = 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response transaction with nothing outstanding: status=%0d count=%0d",
                       rsp_ch.status, rsp_ch.count);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                status_seen[oldest_result.status]++;
                if (rsp_ch.status !== oldest_result.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_result.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.count !== oldest_result.count)
                begin
                    $error("count: expected %0d, got %0d", oldest_result.count, rsp_ch.count);
                    error_count++;
                end
                if (rsp_ch.is_empty !== oldest_result.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d",
                           oldest_result.is_empty, rsp_ch.is_empty);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = MODE_INSERT;
        req_ch.key    = '0;
        rsp_ch.ready  = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (shadow_keys[i])
            shadow_keys[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_insert_erase_basics();
        test_fill_and_overflow();
        test_random_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d requests, peak fill %0d of %0d", sent_count, peak_fill, CAPACITY_DEF);
        $display("responses: inserted %0d, duplicate %0d, full %0d, ",
                 status_seen[ST_INSERTED], status_seen[ST_DUPLICATE], status_seen[ST_FULL],
                 "erased %0d, absent %0d, cleared %0d",
                 status_seen[ST_ERASED], status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED]);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/cst_pkg.sv
rtl/cst_req_if.sv
rtl/cst_rsp_if.sv
rtl/cst_ram.sv
rtl/cst_ctrl.sv
rtl/cst_dp.sv
rtl/compacting_set_table.sv
tb/testbench.sv
